### sv/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer assertion macros
// shared property wrappers clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// property that must hold at every edge out of reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked in the cycle after its trigger
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// geometry, character codes, types and helpers of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COPY_LEN = (ROWS - 1) * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int LOC_W  = 11;
  localparam int WORD_W = 16;
  localparam int WIDE_W = 13;

  // apb register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = '0;

  // character codes
  localparam logic [CODE_W-1:0] CH_BS        = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRINT_MAX = 8'h7F;
  localparam int                TAB_STEP     = 8;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [WORD_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_e;

  // one write port and one read port of the cell store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic step;
    logic home;
  } cur_cmd_t;

  typedef struct packed {
    logic              print;
    logic              scroll;
    logic [ADDR_W-1:0] print_addr;
    logic [LOC_W-1:0]  loc;
  } cur_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

### sv/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// cell store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic                         clk_i,
  input  tcw_pkg::ram_req_t            req_i,
  output logic [tcw_pkg::WORD_W-1:0]   rdata_o
);

  logic [tcw_pkg::WORD_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor registers and the control-code, wrap and scroll decisions
// ----------------------------------------------------------------------------
module tcw_cursor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::cur_cmd_t            cmd_i,
  input  logic [tcw_pkg::CODE_W-1:0]   code_i,
  output tcw_pkg::cur_stat_t           stat_o
);

  localparam int CX_W = tcw_pkg::COL_W + 1;
  localparam int RX_W = tcw_pkg::ROW_W + 1;

  logic [tcw_pkg::COL_W-1:0] col_q, col_d, col_n;
  logic [tcw_pkg::ROW_W-1:0] row_q, row_d, row_n;
  logic [CX_W-1:0]           col_x, col_t;
  logic [RX_W-1:0]           row_x;
  logic                      print, scroll;

  always_comb begin
    col_x  = {1'b0, col_q};
    row_x  = {1'b0, row_q};
    col_t  = col_x + CX_W'(tcw_pkg::TAB_STEP);
    print  = (code_i >= tcw_pkg::CH_SPACE) && (code_i <= tcw_pkg::CH_PRINT_MAX);
    if (code_i == tcw_pkg::CH_BS && col_q != '0) begin
      col_x = col_x - CX_W'(1);
    end
    if (code_i == tcw_pkg::CH_TAB) begin
      col_x = col_t & ~CX_W'(tcw_pkg::TAB_STEP - 1);
    end
    if (code_i == tcw_pkg::CH_CR) begin
      col_x = '0;
    end
    if (code_i == tcw_pkg::CH_LF) begin
      col_x = '0;
      row_x = row_x + RX_W'(1);
    end
    if (print) begin
      col_x = col_x + CX_W'(1);
    end
    // wrap to the next line
    if (col_x >= CX_W'(tcw_pkg::COLUMNS)) begin
      col_x = '0;
      row_x = row_x + RX_W'(1);
    end
    scroll = row_x >= RX_W'(tcw_pkg::ROWS);
    col_n  = col_x[tcw_pkg::COL_W-1:0];
    row_n  = scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_x[tcw_pkg::ROW_W-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.step) begin
      col_d = col_n;
      row_d = row_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign stat_o.print      = print;
  assign stat_o.scroll     = scroll;
  assign stat_o.print_addr = tcw_pkg::cell_addr(row_q, col_q);
  assign stat_o.loc        = tcw_pkg::LOC_W'(tcw_pkg::cell_addr(row_d, col_d));

endmodule

### sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// item sequencer: character writes, cell reads, scroll copy and blanking sweeps
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [tcw_pkg::OP_W-1:0]     op_i,
  input  logic [tcw_pkg::CODE_W-1:0]   char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr_i,
  input  tcw_pkg::cur_stat_t           cur_stat_i,
  input  logic                         out_free_i,
  input  logic [tcw_pkg::WORD_W-1:0]   rdata_i,
  output logic                         in_stall_o,
  output tcw_pkg::cur_cmd_t            cur_cmd_o,
  output tcw_pkg::ram_req_t            ram_req_o,
  output logic                         done_o,
  output logic [tcw_pkg::WORD_W-1:0]   res_data_o
);

  localparam int AW = tcw_pkg::ADDR_W;

  tcw_pkg::state_e             state_q, state_d;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic                        init_q, init_d;
  logic                        rd_ok_q, rd_ok_d;
  logic [tcw_pkg::WORD_W-1:0]  data_q, data_d;
  logic [tcw_pkg::WIDE_W-1:0]  idx_wide;
  logic                        done;
  logic [tcw_pkg::WORD_W-1:0]  res_data;

  assign idx_wide = tcw_pkg::WIDE_W'(cell_index_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    init_d     = init_q;
    rd_ok_d    = rd_ok_q;
    data_d     = data_q;
    done       = 1'b0;
    res_data   = '0;
    in_stall_o = (state_q != tcw_pkg::ST_IDLE);
    cur_cmd_o  = '0;
    ram_req_o  = '0;

    unique case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (tcw_pkg::op_e'(op_i))
            tcw_pkg::OP_WRITE: begin
              cur_cmd_o.step = 1'b1;
              if (cur_stat_i.print) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = cur_stat_i.print_addr;
                ram_req_o.wdata = {attr_i, char_code_i};
              end
              if (cur_stat_i.scroll) begin
                state_d = tcw_pkg::ST_COPY;
                cnt_d   = '0;
              end else begin
                done = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cur_cmd_o.home = 1'b1;
              state_d        = tcw_pkg::ST_BLANK;
              cnt_d          = '0;
            end
            tcw_pkg::OP_READ: begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = idx_wide[AW-1:0];
              rd_ok_d         = idx_wide < tcw_pkg::WIDE_W'(tcw_pkg::CELLS);
              state_d         = tcw_pkg::ST_READ;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        done     = 1'b1;
        res_data = rd_ok_q ? rdata_i : '0;
      end
      tcw_pkg::ST_COPY: begin
        // read runs one line ahead of the write, so no entry is read after rewrite
        if (cnt_q != AW'(tcw_pkg::COPY_LEN)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = cnt_q + AW'(tcw_pkg::COLUMNS);
        end
        if (cnt_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = cnt_q - AW'(1);
          ram_req_o.wdata = rdata_i;
        end
        if (cnt_q == AW'(tcw_pkg::COPY_LEN)) begin
          state_d = tcw_pkg::ST_BLANK;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      tcw_pkg::ST_BLANK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q;
        ram_req_o.wdata = init_q ? tcw_pkg::RESET_BLANK : {attr_i, tcw_pkg::CH_SPACE};
        if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = tcw_pkg::ST_IDLE;
          end else begin
            done = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      tcw_pkg::ST_FINISH: begin
        done     = 1'b1;
        res_data = data_q;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase

    // park the result when the output word is still occupied
    if (done) begin
      if (out_free_i) begin
        state_d = tcw_pkg::ST_IDLE;
      end else begin
        state_d = tcw_pkg::ST_FINISH;
        data_d  = res_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_BLANK;
      cnt_q   <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    data_q  <= data_d;
  end

  assign done_o     = done;
  assign res_data_o = res_data;

endmodule

### sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer - text terminal over a cell store of 80x25 words
// a write without scroll is done in the cycle it is taken, a read passes ST_READ,
// a clear blanks one cell a cycle, a scrolling write copies one cell a cycle
// through the store ports; no word is taken until the reset blanking sweep ends
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tcw_pkg::OP_W-1:0]      op_i,
  input  logic [tcw_pkg::CODE_W-1:0]    char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,

  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcw_pkg::LOC_W-1:0]     cursor_location_o,
  output logic [tcw_pkg::WORD_W-1:0]    cell_data_o,

  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [tcw_pkg::ATTR_W-1:0]  attr_q, attr_d;
  logic                        attr_sel;
  logic                        cfg_we;

  logic                        out_valid_q, out_valid_d;
  logic [tcw_pkg::LOC_W-1:0]   loc_q;
  logic [tcw_pkg::WORD_W-1:0]  data_q;
  logic                        out_free;

  tcw_pkg::cur_cmd_t           cur_cmd;
  tcw_pkg::cur_stat_t          cur_stat;
  tcw_pkg::ram_req_t           ram_req;
  logic [tcw_pkg::WORD_W-1:0]  ram_rdata;
  logic                        done;
  logic [tcw_pkg::WORD_W-1:0]  res_data;

  // --------------------------------------------------------------------------
  // register port: a single attribute register at word 0, zero-wait access
  // --------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign attr_sel = paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_ATTR;
  assign cfg_we   = psel && penable && pwrite && pready;

  always_comb begin
    attr_d = attr_q;
    if (cfg_we && attr_sel) begin
      attr_d = pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  // reads of unused words return zero
  assign prdata = attr_sel ? tcw_pkg::PDATA_W'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::RESET_ATTR;
    end else begin
      attr_q <= attr_d;
    end
  end

  // --------------------------------------------------------------------------
  // datapath: cursor logic, sequencer and the cell store
  // --------------------------------------------------------------------------
  tcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .code_i (char_code_i),
    .stat_o (cur_stat)
  );

  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .cur_stat_i   (cur_stat),
    .out_free_i   (out_free),
    .rdata_i      (ram_rdata),
    .in_stall_o   (in_stall_o),
    .cur_cmd_o    (cur_cmd),
    .ram_req_o    (ram_req),
    .done_o       (done),
    .res_data_o   (res_data)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // output word register: separates the sequencer from the downstream stall,
  // so a new input word can be taken while a result still waits here
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (done && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // cursor location is the value after the item; the cursor is final by now
  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      loc_q  <= cur_stat.loc;
      data_q <= res_data;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_location_o = loc_q;
  assign cell_data_o       = data_q;

endmodule

### sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of word flow and result words of the text console writer
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [tcw_pkg::LOC_W-1:0]     cursor_location_o,
  input  logic [tcw_pkg::WORD_W-1:0]    cell_data_o
);

  logic       in_acc, out_acc;
  logic       out_hold, loc_ok;
  logic [tcw_pkg::LOC_W+tcw_pkg::WORD_W-1:0] out_word;
  logic [2:0] pend_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;
  assign loc_ok   = tcw_pkg::WIDE_W'(cursor_location_o) < tcw_pkg::WIDE_W'(tcw_pkg::CELLS);
  assign out_word = {cursor_location_o, cell_data_o};

  // words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  `TCW_ASSERT(a_inflight_bound, pend_q <= 3'd2, "more than two words in flight")
  `TCW_ASSERT(a_no_spurious_word, out_acc |-> (pend_q != 3'd0), "result word without input")
  `TCW_ASSERT(a_loc_range, out_valid_o |-> loc_ok, "cursor location out of range")
  `TCW_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_word), "stalled word changed")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .cursor_location_o (cursor_location_o),
  .cell_data_o       (cell_data_o)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer testbench
// streams write, clear and read words into the console writer under random
// gaps and stalls, predicts every cursor location and cell word in a shadow
// screen, and reprograms the text attribute between phases
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  // codes with no name in the package
  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [CODE_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CODE_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CODE_W-1:0] CH_HIGH_MIN = 8'h80;
  localparam logic [CODE_W-1:0] CH_HIGH_MAX = 8'hFF;

  localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  // worst case per word: a full scroll or clear sweep, the longest stall and
  // the longest gap; about 900 words at most, taken four times over
  localparam int unsigned CYCLE_LIMIT = 4 * CELLS + 900 * (CELLS + 200) * 4;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  index;
    bit                drain;   // hold this word back until nothing is in flight
  } console_cmd_t;

  typedef struct {
    logic [LOC_W-1:0]  loc;
    logic [WORD_W-1:0] data;
  } console_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input word channel
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i         = '0;
  logic [CODE_W-1:0]   char_code_i  = '0;
  logic [IDX_W-1:0]    cell_index_i = '0;

  // result word channel
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [LOC_W-1:0]    cursor_location_o;
  logic [WORD_W-1:0]   cell_data_o;

  // register port
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  text_console_writer dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the screen, cursor and attribute register
  logic [WORD_W-1:0] screen_cells [CELLS];
  int unsigned       cursor_col;
  int unsigned       cursor_row;
  logic [ATTR_W-1:0] text_attr;

  console_cmd_t    cmd_q[$];      // words waiting for the driver
  console_result_t result_q[$];   // cursor and cell words still owed by the block
  console_cmd_t    live_cmd;      // word currently offered on the input side

  int unsigned cycle_count   = 0;
  int          error_count   = 0;
  int          checked_count = 0;
  int          write_count   = 0;
  int          clear_count   = 0;
  int          read_count    = 0;
  int          read_oob_count = 0;
  int          unused_count  = 0;
  int          scroll_count  = 0;
  int          setting_count = 1;

  // --------------------------------------------------------------------------
  // shadow screen
  // --------------------------------------------------------------------------

  // fill from a cell to the end of the store with blanks in the current attribute
  function automatic void blank_cells(input int unsigned from);
    int unsigned i;
    for (i = from; i < CELLS; i++) screen_cells[i] = {text_attr, CH_SPACE};
  endfunction

  // apply one accepted word to the shadow screen and return what it reports
  function automatic console_result_t console_apply(input console_cmd_t cmd);
    console_result_t res;
    int unsigned     col;
    int unsigned     row;
    int unsigned     i;
    col      = cursor_col;
    row      = cursor_row;
    res.data = '0;
    case (cmd.op)
      OP_WRITE: begin
        write_count++;
        if (cmd.code == CH_BS && col != 0) col--;
        if (cmd.code == CH_TAB) col = (col + TAB_STEP) & ~(TAB_STEP - 1);
        if (cmd.code == CH_CR) col = 0;
        if (cmd.code == CH_LF) begin
          col = 0;
          row++;
        end
        // printable range only; high codes fall through untouched
        if (cmd.code >= CH_SPACE && cmd.code <= CH_PRINT_MAX) begin
          if (row * COLUMNS + col < CELLS) screen_cells[row * COLUMNS + col] = {text_attr, cmd.code};
          col++;
        end
        // wrap past the last column
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
        // scroll past the last row: shift lines up, blank the bottom one
        if (row >= ROWS) begin
          for (i = 0; i < COPY_LEN; i++) screen_cells[i] = screen_cells[i + COLUMNS];
          blank_cells(COPY_LEN);
          row = ROWS - 1;
          scroll_count++;
        end
      end
      OP_CLEAR: begin
        clear_count++;
        blank_cells(0);
        col = 0;
        row = 0;
      end
      OP_READ: begin
        read_count++;
        if (cmd.index < CELLS) res.data = screen_cells[cmd.index];
        else read_oob_count++;
      end
      default: begin
        unused_count++;
      end
    endcase
    cursor_col = col;
    cursor_row = row;
    res.loc    = LOC_W'(row * COLUMNS + col);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------

  function automatic logic [CODE_W-1:0] printable_code();
    return CODE_W'($urandom_range(CH_SPACE, CH_PRINT_MAX));
  endfunction

  // reads lean on the top rows and the bottom rows, where text ends up
  function automatic logic [IDX_W-1:0] read_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return IDX_W'($urandom_range(0, 4 * COLUMNS - 1));
    if (r < 7) return IDX_W'($urandom_range((ROWS - 4) * COLUMNS, CELLS - 1));
    if (r < 9) return IDX_W'($urandom_range(0, CELLS - 1));
    return IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                          input logic [IDX_W-1:0] index, input bit drain);
    console_cmd_t c;
    c.op    = op;
    c.code  = code;
    c.index = index;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // unused fields carry random content
  task automatic push_write(input logic [CODE_W-1:0] code);
    push_cmd(OP_WRITE, code, IDX_W'($urandom_range(0, 2 ** IDX_W - 1)), 1'b0);
  endtask

  task automatic push_read(input logic [IDX_W-1:0] index);
    push_cmd(OP_READ, CODE_W'($urandom_range(0, 255)), index, 1'b0);
  endtask

  task automatic push_plain(input logic [OP_W-1:0] op, input bit drain);
    push_cmd(op, CODE_W'($urandom_range(0, 255)),
             IDX_W'($urandom_range(0, 2 ** IDX_W - 1)), drain);
  endtask

  // mixed traffic; lf_pct steers how fast the cursor walks down the screen
  task automatic fill_random(input int n, input int lf_pct, input int clear_pct,
                             input int drain_every);
    int          k;
    int unsigned r;
    int unsigned w;
    bit          drain;
    for (k = 0; k < n; k++) begin
      drain = (drain_every != 0) && (k % drain_every == drain_every - 1);
      r = $urandom_range(0, 99);
      if (r < 27) push_cmd(OP_READ, CODE_W'($urandom_range(0, 255)), read_index(), drain);
      else if (r < 27 + clear_pct) push_plain(OP_CLEAR, drain);
      else if (r < 28 + clear_pct) push_plain(OP_UNUSED, drain);
      else begin
        w = $urandom_range(0, 99);
        if (w < lf_pct) push_cmd(OP_WRITE, CH_LF, '0, drain);
        else if (w < lf_pct + 4) push_cmd(OP_WRITE, CH_CR, '0, drain);
        else if (w < lf_pct + 9) push_cmd(OP_WRITE, CH_BS, '0, drain);
        else if (w < lf_pct + 14) push_cmd(OP_WRITE, CH_TAB, '0, drain);
        else if (w < lf_pct + 24) push_cmd(OP_WRITE, CODE_W'($urandom_range(0, 255)), '0, drain);
        else push_cmd(OP_WRITE, printable_code(), IDX_W'($urandom_range(0, 2 ** IDX_W - 1)),
                      drain);
      end
    end
  endtask

  // park the cursor on the bottom row, then keep pushing lines off the top
  task automatic fill_scroll_phase();
    push_plain(OP_CLEAR, 1'b0);
    repeat (ROWS - 1) push_write(CH_LF);
    repeat (20) push_write(printable_code());
    push_write(CH_LF);
    fill_random(100, 12, 0, 0);
  endtask

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------

  task automatic wait_quiet();
    while (cmd_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
  endtask

  // write the attribute register, then read it back
  task automatic program_attribute(input logic [ATTR_W-1:0] value);
    wait_quiet();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // register takes the value at this edge
    text_attr = value;
    setting_count++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== PDATA_W'(value)) begin
      $error("text_attribute: expected 0x%08h, actual 0x%08h", PDATA_W'(value), prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // input driver: offers queued words with random gaps, predicts on accept
  // --------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i) begin
    logic launch;
    int unsigned r;
    launch = 1'b0;
    if (rst_ni) begin
      // word taken at this edge
      if (in_valid_i && !in_stall_o) result_q.push_back(console_apply(live_cmd));
      // channel free: either idle out the gap or offer the next word
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) send_gap--;
        else if (cmd_q.size() != 0 && (!cmd_q[0].drain || result_q.size() == 0)) begin
          live_cmd = cmd_q.pop_front();
          launch   = 1'b1;
          if (send_calm > 0) send_calm--;
          else begin
            r = $urandom_range(0, 99);
            if (r < 60) send_gap = 0;
            else if (r < 88) send_gap = $urandom_range(1, 3);
            else if (r < 97) send_gap = $urandom_range(4, 12);
            else send_gap = $urandom_range(20, 60);
            // now and then a back-to-back stretch
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
          end
        end
        in_valid_i <= launch;
        if (launch) begin
          op_i         <= live_cmd.op;
          char_code_i  <= live_cmd.code;
          cell_index_i <= live_cmd.index;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: random stall, field by field compare with the oldest word
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned take_calm  = 0;

  always @(posedge clk_i) begin
    console_result_t want;
    logic            stall_next;
    int unsigned     r;
    stall_next = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        checked_count++;
        if (result_q.size() == 0) begin
          $error("result word with none expected: cursor_location %0d, cell_data 0x%04h",
                 cursor_location_o, cell_data_o);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (cursor_location_o !== want.loc) begin
            $error("cursor_location: expected %0d, actual %0d", want.loc, cursor_location_o);
            error_count++;
          end
          if (cell_data_o !== want.data) begin
            $error("cell_data: expected 0x%04h, actual 0x%04h", want.data, cell_data_o);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (take_calm > 0) begin
        take_calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 97 && r >= 70) begin
          stall_left = $urandom_range(0, 3);
          stall_next = 1'b1;
        end else if (r < 99 && r >= 97) begin
          stall_left = $urandom_range(15, 50);
          stall_next = 1'b1;
        end else if (r == 99) begin
          take_calm = $urandom_range(50, 200);
        end
      end
      out_stall_i <= stall_next;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_writer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // phases
  // --------------------------------------------------------------------------
  initial begin
    text_attr  = RESET_ATTR;
    cursor_col = 0;
    cursor_row = 0;
    blank_cells(0);

    // directed opening under the reset attribute: store edges, reads past the
    // store, every control code, the printable bounds, high and stray codes
    push_read(IDX_W'(0));
    push_read(IDX_W'(CELLS - 1));
    push_read(IDX_W'(CELLS));
    push_read(IDX_W'(2 ** IDX_W - 1));
    push_write(CH_SPACE);
    push_write(CH_PRINT_MAX);
    push_write(8'h55);
    push_write(CH_BS);
    push_write(CH_TAB);
    push_write(CH_TAB);
    push_write(CH_CR);
    push_write(CH_BS);          // backspace at column 0 stays put
    push_write(CH_HIGH_MIN);
    push_write(CH_HIGH_MAX);
    push_write(CH_NUL);
    push_write(CH_ESC);
    push_write(CH_LF);
    push_read(IDX_W'(0));
    push_read(IDX_W'(1));
    push_plain(OP_UNUSED, 1'b0);
    push_plain(OP_CLEAR, 1'b1);
    push_read(IDX_W'(1));
    fill_random(80, 6, 2, 0);

    // reset release; the block's blanking sweep follows
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full lines: tab off the last column wraps, then an exact 80-char line
    program_attribute(8'h00);
    push_plain(OP_CLEAR, 1'b0);
    repeat (COLUMNS - 1) push_write(printable_code());
    push_write(CH_TAB);
    repeat (COLUMNS) push_write(printable_code());
    fill_random(20, 6, 2, 0);

    program_attribute(8'hFF);
    fill_scroll_phase();

    // sender pauses for a full drain every so often
    program_attribute(ATTR_W'($urandom_range(1, 254)));
    fill_random(100, 6, 2, 25);

    program_attribute(ATTR_W'($urandom_range(1, 254)));
    fill_scroll_phase();

    program_attribute(RESET_ATTR);
    fill_random(80, 8, 2, 0);

    // everything accepted and answered; leave room for a stray late word
    wait_quiet();
    repeat (CELLS + 100) @(posedge clk_i);

    $display("covered %0d writes (%0d scrolls), %0d clears, %0d reads (%0d past the store),",
             write_count, scroll_count, clear_count, read_count, read_oob_count);
    $display("  %0d unused-op words, %0d attribute settings, %0d result words checked",
             unused_count, setting_count, checked_count);
    if (error_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
